// ===== hdl/cli_pkg.sv =====
// Shared types, widths and helpers for the conic / axis-line intersection block.
`timescale 1ns / 1ps
package cli_pkg;

    localparam int WORD_W    = 32;                   // Q16.16 word
    localparam int FRAC_W    = 16;                   // fraction bits
    localparam int PROD_W    = 2 * WORD_W;           // full product
    localparam int WIDE_W    = PROD_W + 3;           // headroom for sums of products
    localparam int DISC_W    = PROD_W + 2;           // clamped discriminant, unsigned
    localparam int ROOT_W    = DISC_W / 2;           // square root bits
    localparam int MAG_W     = ROOT_W + 1;           // |-b +/- s|
    localparam int NUM_W     = MAG_W + FRAC_W;       // dividend bits
    localparam int DIV_W     = WORD_W + 1;           // divisor 2|a|
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WW = 3'd5;

    // line kinds
    localparam logic CMD_FIXED_X = 1'b0;

    // smallest raw discriminant kept (1e-10 in Q(2F))
    localparam logic [DISC_W-1:0] DISC_MIN = DISC_W'(
        ((64'd1 << (2 * FRAC_W)) - 64'd1) / 64'd10000000000 + 64'd1);

    localparam logic signed [WIDE_W-1:0] WORD_MAX_W =
        {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WORD_MIN_W =
        {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    typedef logic signed [WORD_W-1:0] t_word;

    // classified request handed from front to back
    typedef struct packed {
        logic  degen;
        t_word a;
        t_word qk;
        t_word sa;
        t_word sb;
        t_word u;
    } t_item;

    // clamp to the word range; top bit flags a clamp
    function automatic logic [WORD_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic [WORD_W:0] res;
        if (v > WORD_MAX_W) begin
            res = {1'b1, WORD_MAX_W[WORD_W-1:0]};
        end else if (v < WORD_MIN_W) begin
            res = {1'b1, WORD_MIN_W[WORD_W-1:0]};
        end else begin
            res = {1'b0, v[WORD_W-1:0]};
        end
        return res;
    endfunction

endpackage

// ===== hdl/cli_front.sv =====
// Front end: accept requests, select coefficients by line kind, queue them.
`timescale 1ns / 1ps
module cli_front import cli_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_cmd,
    input  t_word i_coord,
    input  t_word i_xx,
    input  t_word i_xw,
    input  t_word i_yy,
    input  t_word i_yw,
    output logic  o_item_vld,
    output t_item o_item,
    input  logic  i_pop
);

    t_item               r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;
    t_item               w_item;
    logic                w_push, w_pop;

    always_comb begin
        w_item.u = i_coord;
        if (i_cmd == CMD_FIXED_X) begin
            w_item.a  = i_yy;
            w_item.qk = i_yw;
            w_item.sa = i_xx;
            w_item.sb = i_xw;
        end else begin
            w_item.a  = i_xx;
            w_item.qk = i_xw;
            w_item.sa = i_yy;
            w_item.sb = i_yw;
        end
        w_item.degen = (w_item.a == '0);
    end

    assign o_ready    = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_item_vld = (r_cnt != '0);
    assign o_item     = r_q[r_rd];
    assign w_push     = i_valid && o_ready;
    assign w_pop      = i_pop && o_item_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_item;
    end

endmodule

// ===== hdl/cli_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module cli_sqrt import cli_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [DISC_W-1:0] i_rad,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]   o_sb
);

    localparam int RW = ROOT_W + 4;

    logic              st_vld  [ROOT_W+1];
    logic [RW-1:0]     st_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] st_root [ROOT_W+1];
    logic [DISC_W-1:0] st_rad  [ROOT_W+1];
    logic [SB_W-1:0]   st_sb   [ROOT_W+1];

    assign st_vld[0]  = i_vld;
    assign st_rem[0]  = '0;
    assign st_root[0] = '0;
    assign st_rad[0]  = i_rad;
    assign st_sb[0]   = i_sb;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [RW-1:0] w_tmp, w_trial;
        logic          w_ge;
        always_comb begin
            w_tmp   = {st_rem[g][RW-3:0], st_rad[g][DISC_W-1 -: 2]};
            w_trial = RW'({st_root[g], 2'b01});
            w_ge    = (w_tmp >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                st_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                st_vld[g+1] <= st_vld[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                st_rem[g+1]  <= w_ge ? (w_tmp - w_trial) : w_tmp;
                st_root[g+1] <= {st_root[g][ROOT_W-2:0], w_ge};
                st_rad[g+1]  <= {st_rad[g][DISC_W-3:0], 2'b00};
                st_sb[g+1]   <= st_sb[g];
            end
        end
    end

    assign o_vld  = st_vld[ROOT_W];
    assign o_root = st_root[ROOT_W];
    assign o_sb   = st_sb[ROOT_W];

endmodule

// ===== hdl/cli_div.sv =====
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module cli_div import cli_pkg::*; #(
    parameter int SB_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num_p,
    input  logic [NUM_W-1:0] i_num_m,
    input  logic [DIV_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_vld,
    output logic [NUM_W-1:0] o_q_p,
    output logic [NUM_W-1:0] o_q_m,
    output logic [SB_W-1:0]  o_sb
);

    localparam int RW = DIV_W + 1;

    logic             st_vld [NUM_W+1];
    logic [DIV_W-1:0] st_den [NUM_W+1];
    logic [SB_W-1:0]  st_sb  [NUM_W+1];
    logic [NUM_W-1:0] st_n_p [NUM_W+1];
    logic [NUM_W-1:0] st_n_m [NUM_W+1];
    logic [NUM_W-1:0] st_q_p [NUM_W+1];
    logic [NUM_W-1:0] st_q_m [NUM_W+1];
    logic [RW-1:0]    st_r_p [NUM_W+1];
    logic [RW-1:0]    st_r_m [NUM_W+1];

    assign st_vld[0] = i_vld;
    assign st_den[0] = i_den;
    assign st_sb[0]  = i_sb;
    assign st_n_p[0] = i_num_p;
    assign st_n_m[0] = i_num_m;
    assign st_q_p[0] = '0;
    assign st_q_m[0] = '0;
    assign st_r_p[0] = '0;
    assign st_r_m[0] = '0;

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [RW-1:0] w_tp, w_tm, w_d;
        logic          w_gp, w_gm;
        always_comb begin
            w_d  = RW'(st_den[g]);
            w_tp = {st_r_p[g][RW-2:0], st_n_p[g][NUM_W-1]};
            w_tm = {st_r_m[g][RW-2:0], st_n_m[g][NUM_W-1]};
            w_gp = (w_tp >= w_d);
            w_gm = (w_tm >= w_d);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                st_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                st_vld[g+1] <= st_vld[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                st_den[g+1] <= st_den[g];
                st_sb[g+1]  <= st_sb[g];
                st_n_p[g+1] <= {st_n_p[g][NUM_W-2:0], 1'b0};
                st_n_m[g+1] <= {st_n_m[g][NUM_W-2:0], 1'b0};
                st_r_p[g+1] <= w_gp ? (w_tp - w_d) : w_tp;
                st_r_m[g+1] <= w_gm ? (w_tm - w_d) : w_tm;
                st_q_p[g+1] <= {st_q_p[g][NUM_W-2:0], w_gp};
                st_q_m[g+1] <= {st_q_m[g][NUM_W-2:0], w_gm};
            end
        end
    end

    assign o_vld = st_vld[NUM_W];
    assign o_q_p = st_q_p[NUM_W];
    assign o_q_m = st_q_m[NUM_W];
    assign o_sb  = st_sb[NUM_W];

endmodule

// ===== hdl/cli_back.sv =====
// Back end: coefficients, discriminant, square root, division and output register.
`timescale 1ns / 1ps
module cli_back import cli_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_item_vld,
    input  t_item        i_item,
    output logic         o_pop,
    input  t_word        i_xy,
    input  t_word        i_ww,
    output logic         o_vld,
    input  logic         i_ready,
    output t_word        o_root_p,
    output t_word        o_root_m,
    output logic         o_degen,
    output logic         o_sat
);

    localparam int SQ_SB = 2 * WORD_W + 2;
    localparam int DV_SB = 4;

    logic w_adv;
    assign w_adv = !o_vld || i_ready;
    assign o_pop = w_adv;

    // stage 1: products with u
    logic                     r1_vld, r1_degen;
    t_word                    r1_a, r1_u, r1_qk;
    logic signed [PROD_W-1:0] r1_lu, r1_au, r1_bu;
    // stage 2: b and t
    logic                     r2_vld, r2_degen, r2_clip;
    t_word                    r2_a, r2_u, r2_b, r2_t;
    logic signed [PROD_W-1:0] r2_bu;
    // stage 3: t*u
    logic                     r3_vld, r3_degen, r3_clip;
    t_word                    r3_a, r3_b;
    logic signed [PROD_W-1:0] r3_bu, r3_tu;
    // stage 4: c
    logic                     r4_vld, r4_degen, r4_clip;
    t_word                    r4_a, r4_b, r4_c;
    // stage 5: b*b and a*c
    logic                     r5_vld, r5_degen, r5_clip;
    t_word                    r5_a, r5_b;
    logic signed [PROD_W-1:0] r5_bb, r5_ac;
    // stage 6: clamped discriminant
    logic                     r6_vld;
    logic [DISC_W-1:0]        r6_disc;
    logic [SQ_SB-1:0]         r6_sb;

    logic [WORD_W:0]          w_b, w_t, w_c;
    logic signed [WIDE_W-1:0] w_disc;

    always_comb begin
        w_b = sat_word(((WIDE_W'(r1_lu) <<< 1) >>> FRAC_W) + (WIDE_W'(r1_qk) <<< 1));
        w_t = sat_word(WIDE_W'(r1_au) >>> FRAC_W);
        w_c = sat_word(((WIDE_W'(r3_tu) + (WIDE_W'(r3_bu) <<< 1)) >>> FRAC_W)
                       + WIDE_W'(i_ww));
        w_disc = WIDE_W'(r5_bb) - (WIDE_W'(r5_ac) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_item_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_degen <= i_item.degen;
            r1_a     <= i_item.a;
            r1_u     <= i_item.u;
            r1_qk    <= i_item.qk;
            r1_lu    <= i_xy * i_item.u;
            r1_au    <= i_item.sa * i_item.u;
            r1_bu    <= i_item.sb * i_item.u;

            r2_degen <= r1_degen;
            r2_a     <= r1_a;
            r2_u     <= r1_u;
            r2_bu    <= r1_bu;
            r2_b     <= w_b[WORD_W-1:0];
            r2_t     <= w_t[WORD_W-1:0];
            r2_clip  <= w_b[WORD_W] | w_t[WORD_W];

            r3_degen <= r2_degen;
            r3_clip  <= r2_clip;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_bu    <= r2_bu;
            r3_tu    <= r2_t * r2_u;

            r4_degen <= r3_degen;
            r4_clip  <= r3_clip | w_c[WORD_W];
            r4_a     <= r3_a;
            r4_b     <= r3_b;
            r4_c     <= w_c[WORD_W-1:0];

            r5_degen <= r4_degen;
            r5_clip  <= r4_clip;
            r5_a     <= r4_a;
            r5_b     <= r4_b;
            r5_bb    <= r4_b * r4_b;
            r5_ac    <= r4_a * r4_c;

            // drop small or negative discriminants to zero
            if (w_disc[WIDE_W-1] || (w_disc[DISC_W-1:0] < DISC_MIN)) begin
                r6_disc <= '0;
            end else begin
                r6_disc <= w_disc[DISC_W-1:0];
            end
            r6_sb <= {r5_a, r5_b, r5_clip, r5_degen};
        end
    end

    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_sq_root;
    logic [SQ_SB-1:0]  w_sq_sb;

    cli_sqrt #(.SB_W(SQ_SB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r6_vld),
        .i_rad   (r6_disc),
        .i_sb    (r6_sb),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_sb    (w_sq_sb)
    );

    // stage 7: numerators and divisor
    t_word                    w_sa, w_sbv;
    logic signed [WIDE_W-1:0] w_np, w_nm, w_s, w_mp, w_mm;
    logic signed [DIV_W-1:0]  w_ae, w_aa;
    logic                     r7_vld;
    logic [NUM_W-1:0]         r7_np, r7_nm;
    logic [DIV_W-1:0]         r7_den;
    logic [DV_SB-1:0]         r7_sb;

    always_comb begin
        w_sa  = w_sq_sb[SQ_SB-1 -: WORD_W];
        w_sbv = w_sq_sb[SQ_SB-WORD_W-1 -: WORD_W];
        w_s   = signed'(WIDE_W'(w_sq_root));
        w_np  = w_s - WIDE_W'(w_sbv);
        w_nm  = -w_s - WIDE_W'(w_sbv);
        w_mp  = w_np[WIDE_W-1] ? -w_np : w_np;
        w_mm  = w_nm[WIDE_W-1] ? -w_nm : w_nm;
        w_ae  = DIV_W'(w_sa);
        w_aa  = w_ae[DIV_W-1] ? -w_ae : w_ae;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r7_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_np  <= {w_mp[MAG_W-1:0], {FRAC_W{1'b0}}};
            r7_nm  <= {w_mm[MAG_W-1:0], {FRAC_W{1'b0}}};
            r7_den <= {w_aa[WORD_W-1:0], 1'b0};
            r7_sb  <= {w_np[WIDE_W-1] ^ w_sa[WORD_W-1],
                       w_nm[WIDE_W-1] ^ w_sa[WORD_W-1],
                       w_sq_sb[1], w_sq_sb[0]};
        end
    end

    logic             w_dv_vld;
    logic [NUM_W-1:0] w_qp, w_qm;
    logic [DV_SB-1:0] w_dv_sb;

    cli_div #(.SB_W(DV_SB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r7_vld),
        .i_num_p (r7_np),
        .i_num_m (r7_nm),
        .i_den   (r7_den),
        .i_sb    (r7_sb),
        .o_vld   (w_dv_vld),
        .o_q_p   (w_qp),
        .o_q_m   (w_qm),
        .o_sb    (w_dv_sb)
    );

    // final: sign, clamp, degenerate override
    logic signed [WIDE_W-1:0] w_qsp, w_qsm;
    logic [WORD_W:0]          w_rp, w_rm;

    always_comb begin
        w_qsp = signed'(WIDE_W'(w_qp));
        w_qsm = signed'(WIDE_W'(w_qm));
        w_rp  = sat_word(w_dv_sb[3] ? -w_qsp : w_qsp);
        w_rm  = sat_word(w_dv_sb[2] ? -w_qsm : w_qsm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (w_adv) begin
            o_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_dv_sb[0]) begin
                o_root_p <= '0;
                o_root_m <= '0;
                o_degen  <= 1'b1;
                o_sat    <= 1'b0;
            end else begin
                o_root_p <= w_rp[WORD_W-1:0];
                o_root_m <= w_rm[WORD_W-1:0];
                o_degen  <= 1'b0;
                o_sat    <= w_dv_sb[1] | w_rp[WORD_W] | w_rm[WORD_W];
            end
        end
    end

endmodule

// ===== hdl/conic_line_intersection.sv =====
// Top level: conic / axis-line intersection, configuration registers and stream ports.
// Path: an accepted request waits in the queue, then passes the coefficient and discriminant
//   stages, the square root (one bit per stage), operand setup, the dividers and the output
//   register; the queue holds each request in a register before stage 1 reads its head.
// Throughput: one request per cycle unless stalled; every back-end stage is a register.
// Back pressure freezes the whole back end; the 4-entry queue accepts requests until full.
// Reset (synchronous, active low) clears the conic registers to zero and empties the
//   queue and all pipeline valid bits; no clearing pass.
`timescale 1ns / 1ps
module conic_line_intersection import cli_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request side
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [WORD_W-1:0]    i_s_tdata,    // [31:0] coord_value
    input  logic                 i_s_tuser,    // [0] cmd
    // result side
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [2*WORD_W-1:0]  o_m_tdata,    // [31:0] root_plus, [63:32] root_minus
    output logic [1:0]           o_m_tuser,    // [0] degenerate, [1] saturated
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // conic entries; the user must write them only while idle, the block does not enforce it
    t_word r_xx, r_xy, r_xw, r_yy, r_yw, r_ww;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx <= '0;
            r_xy <= '0;
            r_xw <= '0;
            r_yy <= '0;
            r_yw <= '0;
            r_ww <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_XX:  r_xx <= i_cfg_data;
                REG_XY:  r_xy <= i_cfg_data;
                REG_XW:  r_xw <= i_cfg_data;
                REG_YY:  r_yy <= i_cfg_data;
                REG_YW:  r_yw <= i_cfg_data;
                REG_WW:  r_ww <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // front: pick the leading, linear and constant terms by line kind, then queue
    logic  w_item_vld, w_pop;
    t_item w_item;

    cli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_coord    (i_s_tdata),
        .i_xx       (r_xx),
        .i_xw       (r_xw),
        .i_yy       (r_yy),
        .i_yw       (r_yw),
        .o_item_vld (w_item_vld),
        .o_item     (w_item),
        .i_pop      (w_pop)
    );

    // back: quadratic coefficients, discriminant, square root, both divisions
    t_word w_rp, w_rm;
    logic  w_degen, w_sat;

    cli_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_vld (w_item_vld),
        .i_item     (w_item),
        .o_pop      (w_pop),
        .i_xy       (r_xy),
        .i_ww       (r_ww),
        .o_vld      (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_root_p   (w_rp),
        .o_root_m   (w_rm),
        .o_degen    (w_degen),
        .o_sat      (w_sat)
    );

    assign o_m_tdata = {w_rm, w_rp};
    assign o_m_tuser = {w_sat, w_degen};

endmodule
